/* hdl/lrbv_pkg.sv */
// ----------------------------------------------------------------------------
// lrbv_pkg: shared types and constants for landmark range/bearing/visibility
// Formats, CORDIC angle table and the beat carried along the cell chain.
// ----------------------------------------------------------------------------
package lrbv_pkg;

    localparam int CORDIC_STAGES = 16;       // 8..24
    localparam int NUM_CELLS     = 25;       // one root bit per cell, >= CORDIC_STAGES
    localparam int CELL_IDX_W    = 5;

    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 72;

    // configuration register indexes
    localparam logic REG_FOV_LIMIT = 1'b0;
    localparam logic REG_MAX_RANGE = 1'b1;

    // Q3.13 angles, 20 bit signed
    localparam logic signed [19:0] PI_Q13      = 20'sd25736;
    localparam logic signed [19:0] TWO_PI_Q13  = 20'sd51472;
    localparam logic signed [19:0] HALF_PI_Q13 = 20'sd12868;
    localparam logic signed [19:0] SIX_PI_Q13  = 20'sd154416;
    localparam logic signed [19:0] EIGHT_PI_Q13 = 20'sd205888;
    localparam logic signed [19:0] FOUR_PI_Q13 = 20'sd102944;

    localparam logic signed [33:0] PI_Q29    = 34'sd1686629713;
    localparam logic [30:0]        PI_Q29_U  = 31'd1686629713;

    typedef struct packed {
        logic               valid;
        logic [9:0]         id;
        logic signed [15:0] hd;
        logic signed [19:0] d;      // landmark angle minus heading, Q3.13
        logic               zero;   // coincident points
        logic signed [35:0] x;
        logic signed [35:0] y;
        logic signed [33:0] z;      // Q2.29
        logic [49:0]        rem;    // radicand remainder
        logic [24:0]        root;
    } lrbv_cell_t;

    function automatic logic signed [33:0] atan_q29(input logic [CELL_IDX_W-1:0] idx);
        case (idx)
            5'd0:  atan_q29 = 34'sd421657428;
            5'd1:  atan_q29 = 34'sd248918915;
            5'd2:  atan_q29 = 34'sd131521918;
            5'd3:  atan_q29 = 34'sd66762579;
            5'd4:  atan_q29 = 34'sd33510843;
            5'd5:  atan_q29 = 34'sd16771758;
            5'd6:  atan_q29 = 34'sd8387925;
            5'd7:  atan_q29 = 34'sd4194219;
            5'd8:  atan_q29 = 34'sd2097141;
            5'd9:  atan_q29 = 34'sd1048575;
            5'd10: atan_q29 = 34'sd524288;
            5'd11: atan_q29 = 34'sd262144;
            5'd12: atan_q29 = 34'sd131072;
            5'd13: atan_q29 = 34'sd65536;
            5'd14: atan_q29 = 34'sd32768;
            5'd15: atan_q29 = 34'sd16384;
            5'd16: atan_q29 = 34'sd8192;
            5'd17: atan_q29 = 34'sd4096;
            5'd18: atan_q29 = 34'sd2048;
            5'd19: atan_q29 = 34'sd1024;
            5'd20: atan_q29 = 34'sd512;
            5'd21: atan_q29 = 34'sd256;
            5'd22: atan_q29 = 34'sd128;
            5'd23: atan_q29 = 34'sd64;
            default: atan_q29 = 34'sd0;
        endcase
    endfunction

endpackage

/* hdl/landmark_range_bearing_visibility.sv */
// ----------------------------------------------------------------------------
// landmark_range_bearing_visibility: range, bearing, viewing angle, visibility
// Pipeline from input beat to output beat: 4 front stages, 25 chain cells,
//   2 back stages, output register; the bit-per-cell root chain sets the depth.
// Throughput: one beat per cycle while the output beat is not held.
// Reset: aresetn synchronous active low, clears stage valids and registers
//   fov_limit to 4289 and max_range to 163840.
// ----------------------------------------------------------------------------
module landmark_range_bearing_visibility import lrbv_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // slave: robot_x, robot_y, robot_heading, landmark_id, landmark_x,
    //        landmark_y, landmark_orientation (from bit 0 up), zero pad
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // master: visible, out_id, range_m, bearing, viewing_angle, zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // configuration write port
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [24:0]            cfg_data
);

    logic [14:0] fov_limit_reg;
    logic [24:0] max_range_reg;
    logic        pipe_en;

    lrbv_cell_t chain [0:NUM_CELLS];

    // whole pipe advances unless the output beat is held
    assign pipe_en  = !m_tvalid || m_tready;
    assign s_tready = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fov_limit_reg <= 15'd4289;
            max_range_reg <= 25'd163840;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FOV_LIMIT: fov_limit_reg <= cfg_data[14:0];
                REG_MAX_RANGE: max_range_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    lrbv_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (pipe_en),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .cell_out (chain[0])
    );

    // cell i: CORDIC micro-rotation i (while i < CORDIC_STAGES) and root bit 24-i
    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        lrbv_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (pipe_en),
            .cell_idx (CELL_IDX_W'(i)),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    // root never exceeds 2^25-1, so range needs no clamp
    lrbv_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .cell_in   (chain[NUM_CELLS]),
        .fov_limit (fov_limit_reg),
        .max_range (max_range_reg),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

    // folded viewing angle never exceeds pi/2
    a_view_fold : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[65:52] <= 14'd12868))
        else $error("viewing angle beyond pi/2");

    // no output beat straight after reset
    a_reset_empty : assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_tvalid)
        else $error("output valid after reset");

    // pad bits stay zero
    a_pad_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[71:66] == 6'd0))
        else $error("output pad bits set");

endmodule

/* hdl/lrbv_front.sv */
// ----------------------------------------------------------------------------
// lrbv_front: input stages
// Differences, squares, CORDIC pre-rotation and landmark angle minus heading.
// ----------------------------------------------------------------------------
module lrbv_front import lrbv_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [IN_TDATA_W-1:0] in_data,
    output lrbv_cell_t            cell_out
);

    // stage 0
    logic               v0_reg;
    logic signed [24:0] dx0_reg, dy0_reg;
    logic signed [15:0] hd0_reg, ori0_reg;
    logic [9:0]         id0_reg;

    // stage 1
    logic               v1_reg;
    logic [49:0]        sqx1_reg, sqy1_reg;
    logic [46:0]        mag1_reg;
    logic               ori_neg1_reg, zero1_reg;
    logic signed [35:0] x1_reg, y1_reg;
    logic signed [33:0] z1_reg;
    logic signed [15:0] hd1_reg;
    logic [9:0]         id1_reg;

    // stage 2
    logic               v2_reg;
    logic [49:0]        rad2_reg;
    logic signed [19:0] th2_reg;
    logic               zero2_reg;
    logic signed [35:0] x2_reg, y2_reg;
    logic signed [33:0] z2_reg;
    logic signed [15:0] hd2_reg;
    logic [9:0]         id2_reg;

    lrbv_cell_t cell_reg, cell_next;

    logic signed [23:0] rx, ry, lx, ly;
    logic [24:0]        adx, ady;
    logic [15:0]        ori_mag;
    logic signed [35:0] xs, ys;
    logic [47:0]        th_sum;
    logic [17:0]        th_mag;

    assign rx = in_data[23:0];
    assign ry = in_data[47:24];
    assign lx = in_data[97:74];
    assign ly = in_data[121:98];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
        end
        if (en) begin
            dx0_reg  <= 25'(lx) - 25'(rx);
            dy0_reg  <= 25'(ly) - 25'(ry);
            hd0_reg  <= in_data[63:48];
            id0_reg  <= in_data[73:64];
            ori0_reg <= in_data[137:122];
        end
    end

    always_comb begin
        adx     = dx0_reg[24] ? 25'(-dx0_reg) : 25'(dx0_reg);
        ady     = dy0_reg[24] ? 25'(-dy0_reg) : 25'(dy0_reg);
        ori_mag = ori0_reg[15] ? 16'(-ori0_reg) : 16'(ori0_reg);
        xs      = 36'(dx0_reg) <<< 8;
        ys      = 36'(dy0_reg) <<< 8;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v0_reg;
        end
        if (en) begin
            sqx1_reg     <= 50'(adx * adx);
            sqy1_reg     <= 50'(ady * ady);
            mag1_reg     <= 47'(ori_mag * PI_Q29_U);
            ori_neg1_reg <= ori0_reg[15];
            zero1_reg    <= (dx0_reg == '0) && (dy0_reg == '0);
            // left half plane: rotate by pi first
            if (dx0_reg[24]) begin
                x1_reg <= -xs;
                y1_reg <= -ys;
                z1_reg <= dy0_reg[24] ? -PI_Q29 : PI_Q29;
            end else begin
                x1_reg <= xs;
                y1_reg <= ys;
                z1_reg <= '0;
            end
            hd1_reg <= hd0_reg;
            id1_reg <= id0_reg;
        end
    end

    assign th_sum = {1'b0, mag1_reg} + 48'(1 << 29);
    assign th_mag = th_sum[47:30];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            rad2_reg  <= sqx1_reg + sqy1_reg;
            th2_reg   <= ori_neg1_reg ? -$signed({2'b0, th_mag}) : $signed({2'b0, th_mag});
            zero2_reg <= zero1_reg;
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            z2_reg    <= z1_reg;
            hd2_reg   <= hd1_reg;
            id2_reg   <= id1_reg;
        end
    end

    always_comb begin
        cell_next.valid = v2_reg;
        cell_next.id    = id2_reg;
        cell_next.hd    = hd2_reg;
        cell_next.d     = th2_reg - 20'(hd2_reg);
        cell_next.zero  = zero2_reg;
        cell_next.x     = x2_reg;
        cell_next.y     = y2_reg;
        cell_next.z     = z2_reg;
        cell_next.rem   = rad2_reg;
        cell_next.root  = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

/* hdl/lrbv_cell.sv */
// ----------------------------------------------------------------------------
// lrbv_cell: one link of the chain
// CORDIC vectoring micro-rotation (idx < CORDIC_STAGES), one integer sqrt bit.
// ----------------------------------------------------------------------------
module lrbv_cell import lrbv_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic [CELL_IDX_W-1:0] cell_idx,
    input  lrbv_cell_t            cell_in,
    output lrbv_cell_t            cell_out
);

    lrbv_cell_t cell_reg, cell_next;

    logic signed [35:0]    xs, ys;
    logic signed [33:0]    ang;
    logic [CELL_IDX_W-1:0] bit_pos;
    logic [51:0]           trial;

    always_comb begin
        xs      = cell_in.x >>> cell_idx;
        ys      = cell_in.y >>> cell_idx;
        ang     = atan_q29(cell_idx);
        bit_pos = CELL_IDX_W'(NUM_CELLS - 1) - cell_idx;
        // (r + 2^b)^2 - r^2
        trial   = ({27'b0, cell_in.root} << (bit_pos + 1'b1))
                + (52'd1 << {bit_pos, 1'b0});

        cell_next = cell_in;
        if (32'(cell_idx) < CORDIC_STAGES) begin
            if (!cell_in.y[35]) begin
                cell_next.x = cell_in.x + ys;
                cell_next.y = cell_in.y - xs;
                cell_next.z = cell_in.z + ang;
            end else begin
                cell_next.x = cell_in.x - ys;
                cell_next.y = cell_in.y + xs;
                cell_next.z = cell_in.z - ang;
            end
        end
        if ({2'b0, cell_in.rem} >= trial) begin
            cell_next.rem  = 50'({2'b0, cell_in.rem} - trial);
            cell_next.root = cell_in.root | (25'd1 << bit_pos);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

/* hdl/lrbv_back.sv */
// ----------------------------------------------------------------------------
// lrbv_back: output stages
// Bearing wrap, viewing angle reduction and fold, visibility, output register.
// ----------------------------------------------------------------------------
module lrbv_back import lrbv_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  lrbv_cell_t             cell_in,
    input  logic [14:0]            fov_limit,
    input  logic [24:0]            max_range,
    output logic                   out_valid,
    output logic [OUT_TDATA_W-1:0] out_data
);

    logic               v0_reg, v1_reg, out_valid_reg;
    logic signed [19:0] brg0_reg, brg1_reg, d0_reg, d1_reg;
    logic [24:0]        rng0_reg, rng1_reg;
    logic [9:0]         id0_reg, id1_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic [35:0]        z_sum;
    logic signed [19:0] ang, da, db, dc, dd, bw, bw2, fa, fb;
    logic [19:0]        bmag;
    logic               vis;

    always_comb begin
        z_sum = 36'(cell_in.z) + 36'd32768;
        ang   = cell_in.zero ? 20'sd0 : 20'($signed(z_sum) >>> 16);
        da    = cell_in.d[19] ? cell_in.d + SIX_PI_Q13 : cell_in.d;
        db    = (da >= EIGHT_PI_Q13) ? da - EIGHT_PI_Q13 : da;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= cell_in.valid;
        end
        if (en) begin
            brg0_reg <= ang - 20'(cell_in.hd);
            d0_reg   <= db;
            rng0_reg <= cell_in.root;
            id0_reg  <= cell_in.id;
        end
    end

    always_comb begin
        bw  = (brg0_reg > PI_Q13) ? brg0_reg - TWO_PI_Q13 : brg0_reg;
        bw2 = (bw < -PI_Q13) ? bw + TWO_PI_Q13 : bw;
        dc  = (d0_reg >= FOUR_PI_Q13) ? d0_reg - FOUR_PI_Q13 : d0_reg;
        dd  = (dc >= TWO_PI_Q13) ? dc - TWO_PI_Q13 : dc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v0_reg;
        end
        if (en) begin
            brg1_reg <= bw2;
            d1_reg   <= dd;
            rng1_reg <= rng0_reg;
            id1_reg  <= id0_reg;
        end
    end

    always_comb begin
        fa   = (d1_reg > PI_Q13) ? TWO_PI_Q13 - d1_reg : d1_reg;
        fb   = (fa > HALF_PI_Q13) ? PI_Q13 - fa : fa;
        bmag = brg1_reg[19] ? 20'(-brg1_reg) : 20'(brg1_reg);
        vis  = (bmag < {5'b0, fov_limit}) && (rng1_reg < max_range);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= v1_reg;
        end
        if (en) begin
            out_data_reg <= {6'b0, fb[13:0], brg1_reg[15:0], rng1_reg, id1_reg, vis};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* tb/sv/landmark_range_bearing_visibility_tb.sv */
// ----------------------------------------------------------------------------
// landmark_range_bearing_visibility_tb: self-checking bench for the landmark
// range, bearing, viewing angle and visibility pipeline.
// Pose/landmark beats are pushed through the stream input under random
// back-pressure; every output beat is checked field by field against an
// in-bench predictor. Register settings are swept between phases.
// ----------------------------------------------------------------------------
module landmark_range_bearing_visibility_tb import lrbv_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY    = 32;
    localparam int STALL_LIMIT = 20000;
    localparam int N_RANDOM   = 450;

    // one input beat, packed as on s_tdata (last field lowest)
    typedef struct packed {
        logic [15:0] ori;
        logic [23:0] ly;
        logic [23:0] lx;
        logic [9:0]  id;
        logic [15:0] hd;
        logic [23:0] ry;
        logic [23:0] rx;
    } pose_t;

    typedef struct packed {
        logic [13:0] view;
        logic [15:0] brg;
        logic [24:0] rng;
        logic [9:0]  id;
        logic        vis;
    } meas_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we = 1'b0;
    logic                   cfg_index = REG_FOV_LIMIT;
    logic [24:0]            cfg_data = '0;

    landmark_range_bearing_visibility u_dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // bench copy of the registers
    logic [14:0] fov_q13 = 15'd4289;
    logic [24:0] range_lim = 25'd163840;

    pose_t pending_poses[$];
    meas_t expected_meas[$];
    int    n_errors = 0;
    bit    calm = 1'b0;        // no idling in the closing part
    bit    stim_done = 1'b0;

    localparam longint ATAN_Q29[24] = '{
        421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
        8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536,
        32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64};

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    // CORDIC vectoring atan2, result Q3.13
    function automatic longint cordic_atan2(longint dx, longint dy);
        longint x, y, z, nx;
        if (dx == 0 && dy == 0) return 0;
        x = dx * 256; y = dy * 256; z = 0;
        if (x < 0) begin
            z = (dy >= 0) ? 64'sd1686629713 : -64'sd1686629713;
            x = -x; y = -y;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            if (y >= 0) begin
                nx = x + floor_shr(y, i); y = y - floor_shr(x, i); z += ATAN_Q29[i];
            end else begin
                nx = x - floor_shr(y, i); y = y + floor_shr(x, i); z -= ATAN_Q29[i];
            end
            x = nx;
        end
        return floor_shr(z + 32768, 16);
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res, one;
        res = 0; one = 64'd1 << 62;
        while (one > n) one >>= 2;
        while (one != 0) begin
            if (n >= res + one) begin
                n -= res + one; res = (res >> 1) + one;
            end else res >>= 1;
            one >>= 2;
        end
        return res;
    endfunction

    function automatic meas_t measure_landmark(pose_t p);
        meas_t m;
        longint dx, dy, rng, brg, hd, ori, th, d;
        longint unsigned mag;
        hd  = longint'($signed(p.hd));
        ori = longint'($signed(p.ori));
        dx  = longint'($signed(p.lx)) - longint'($signed(p.rx));
        dy  = longint'($signed(p.ly)) - longint'($signed(p.ry));
        rng = int_sqrt(longint'(dx * dx + dy * dy));
        if (rng > 33554431) rng = 33554431;
        brg = cordic_atan2(dx, dy) - hd;
        if (brg > 25736) brg -= 51472;
        if (brg < -25736) brg += 51472;
        mag = (ori < 0 ? -ori : ori) * 64'd1686629713;
        th  = longint'((mag + (64'd1 << 29)) >> 30);
        if (ori < 0) th = -th;
        d = (th - hd) % 51472;
        if (d < 0) d += 51472;
        if (d > 25736) d = 51472 - d;
        if (d > 12868) d = 25736 - d;
        m.vis  = ((brg < 0 ? -brg : brg) < fov_q13) && (rng < range_lim);
        m.id   = p.id;
        m.rng  = rng[24:0];
        m.brg  = brg[15:0];
        m.view = d[13:0];
        return m;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    task automatic queue_pose(pose_t p);
        pending_poses = {pending_poses, p};
    endtask

    // driver: idles in bursts, otherwise keeps the next beat on the bus
    int src_idle = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_meas = {expected_meas, measure_landmark(pose_t'(s_tdata[137:0]))};
                void'(pending_poses.pop_front());
            end
            if (src_idle > 0) begin
                src_idle <= src_idle - 1;
                s_tvalid <= 1'b0;
            end else if (!(s_tvalid && !s_tready) && !calm && $urandom_range(0, 9) == 0) begin
                src_idle <= $urandom_range(1, 13);
                s_tvalid <= 1'b0;
            end else if (pending_poses.size() > (s_tvalid && s_tready ? 0 : 0)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= IN_TDATA_W'(pending_poses[0]);
            end else s_tvalid <= 1'b0;
        end
    end

    // monitor plus sink back-pressure
    int sink_idle = 0;
    int quiet = 0;
    always @(posedge aclk) begin
        meas_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = meas_t'(m_tdata[65:0]);
                if (expected_meas.size() == 0) begin
                    report_mismatch("unexpected beat id", got.id, -1);
                end else begin
                    want = expected_meas.pop_front();
                    if (got.vis !== want.vis) report_mismatch("visible", got.vis, want.vis);
                    if (got.id !== want.id) report_mismatch("out_id", got.id, want.id);
                    if (got.rng !== want.rng) report_mismatch("range_m", got.rng, want.rng);
                    if (got.brg !== want.brg)
                        report_mismatch("bearing", $signed(got.brg), $signed(want.brg));
                    if (got.view !== want.view)
                        report_mismatch("viewing_angle", got.view, want.view);
                end
            end
            if (sink_idle > 0) begin
                sink_idle <= sink_idle - 1; m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                sink_idle <= $urandom_range(1, 13); m_tready <= 1'b0;
            end else m_tready <= 1'b1;
            // watchdog on stalls with work outstanding
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
                    || (pending_poses.size() == 0 && expected_meas.size() == 0))
                quiet <= 0;
            else quiet <= quiet + 1;
            if (quiet >= STALL_LIMIT) begin
                $display("landmark_range_bearing_visibility verification failed");
                $finish;
            end
        end
    end

    function automatic logic [23:0] rand_pos(int scale);
        case (scale)
            0: return 24'($signed($urandom_range(0, 400)) - 200);
            1: return 24'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic pose_t random_pose();
        pose_t p;
        int sc;
        sc = $urandom_range(0, 2);
        p.rx = rand_pos(sc);
        p.ry = rand_pos(sc);
        p.lx = (sc == 2) ? rand_pos(2) : p.rx + rand_pos(sc);
        p.ly = (sc == 2) ? rand_pos(2) : p.ry + rand_pos(sc);
        p.id = 10'($urandom());
        p.hd = ($urandom_range(0, 7) == 0) ? 16'($urandom())
                                          : 16'($signed($urandom_range(0, 51472)) - 25736);
        p.ori = ($urandom_range(0, 7) == 0) ? 16'($urandom())
                                           : 16'($signed($urandom_range(0, 32768)) - 16384);
        return p;
    endfunction

    function automatic pose_t make_pose(int rx, int ry, int hd, int id, int lx, int ly, int o);
        pose_t p;
        p.rx = 24'(rx); p.ry = 24'(ry); p.hd = 16'(hd); p.id = 10'(id);
        p.lx = 24'(lx); p.ly = 24'(ly); p.ori = 16'(o);
        return p;
    endfunction

    task automatic wait_drained();
        while (pending_poses.size() != 0 || expected_meas.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [24:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_FOV_LIMIT) fov_q13 = val[14:0];
        else range_lim = val;
    endtask

    initial begin
        logic [14:0] fovs[4];
        logic [24:0] ranges[4];
        fovs   = '{15'd4289, 15'd0, 15'h7FFF, 15'd25736};
        ranges = '{25'd163840, 25'd0, 25'h1FFFFFF, 25'd6445568};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: coincident points, extremes, heading/orientation out of range
        queue_pose(make_pose(0, 0, 0, 0, 0, 0, 0));
        queue_pose(make_pose(100, -50, 300, 1023, 100, -50, 16384));
        queue_pose(make_pose(-8388608, -8388608, 25736, 5,
                             8388607, 8388607, -16384));
        queue_pose(make_pose(8388607, 8388607, -25736, 6,
                             -8388608, -8388608, 16384));
        queue_pose(make_pose(8388607, 0, 0, 7, -8388608, 0, 0));
        queue_pose(make_pose(0, 8388607, 0, 8, 0, -8388608, 0));
        queue_pose(make_pose(0, 0, 32767, 9, -1000, 1, 32767));
        queue_pose(make_pose(0, 0, -32768, 10, -1000, -1, -32768));
        queue_pose(make_pose(0, 0, 0, 11, -5000, 0, 8192));
        queue_pose(make_pose(0, 0, 0, 12, 100000, 1000, -8192));
        queue_pose(make_pose(0, 0, 4288, 13, 100000, 0, 1));
        queue_pose(make_pose(0, 0, 0, 14, 163839, 0, -1));
        queue_pose(make_pose(0, 0, 0, 15, 163840, 0, 0));
        wait_drained();

        // random phases across register settings, extremes included
        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) begin
                write_reg(REG_FOV_LIMIT, (ph < 4) ? 25'(fovs[ph]) : 25'($urandom()) & 25'h7FFF);
                write_reg(REG_MAX_RANGE, (ph < 4) ? ranges[ph] : 25'($urandom()));
            end
            if (ph == 4) calm = 1'b1;
            for (int k = 0; k < N_RANDOM / 5; k++)
                queue_pose(random_pose());
            wait_drained();
        end

        if (n_errors == 0) begin
            $display("landmark_range_bearing_visibility verification clean");
        end else begin
            $display("landmark_range_bearing_visibility verification failed");
        end
        $finish;
    end
endmodule
